>>> hdl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants shared by the bracket balance checker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_ROUND  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;

  localparam logic [7:0] CHAR_OPEN_ROUND   = 8'h28;
  localparam logic [7:0] CHAR_CLOSE_ROUND  = 8'h29;
  localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

  // Command queue between the classifier and the stack engine.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  typedef struct packed {
    op_t   op;
    kind_t kind;
    logic  last;
  } cmd_t;

  function automatic cmd_t classify(input logic [7:0] code, input logic last);
    cmd_t c;
    c.op   = OP_NONE;
    c.kind = KIND_ROUND;
    c.last = last;
    case (code)
      CHAR_OPEN_ROUND: begin
        c.op = OP_PUSH; c.kind = KIND_ROUND;
      end
      CHAR_OPEN_SQUARE: begin
        c.op = OP_PUSH; c.kind = KIND_SQUARE;
      end
      CHAR_OPEN_CURLY: begin
        c.op = OP_PUSH; c.kind = KIND_CURLY;
      end
      CHAR_CLOSE_ROUND: begin
        c.op = OP_POP; c.kind = KIND_ROUND;
      end
      CHAR_CLOSE_SQUARE: begin
        c.op = OP_POP; c.kind = KIND_SQUARE;
      end
      CHAR_CLOSE_CURLY: begin
        c.op = OP_POP; c.kind = KIND_CURLY;
      end
      default: begin
        c.op = OP_NONE;
      end
    endcase
    return c;
  endfunction

endpackage

>>> hdl/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front
// Accepts input words, classifies each byte and registers the command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    char_code,
  input  logic          last_char,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output bbc_pkg::cmd_t cmd
);

  logic vld;

  assign in_ready  = !vld || cmd_ready;
  assign cmd_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (cmd_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= bbc_pkg::classify(char_code, last_char);
    end
  end

endmodule

>>> hdl/bbc_queue.sv
// ----------------------------------------------------------------------------
// bbc_queue
// Small command FIFO that decouples the classifier from the stack engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bbc_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bbc_pkg::cmd_t rd_cmd
);

  bbc_pkg::cmd_t                   slots [bbc_pkg::QUEUE_DEPTH];
  logic [bbc_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [bbc_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [bbc_pkg::QUEUE_CW-1:0]    count;
  logic                            do_wr;
  logic                            do_rd;

  assign wr_ready = (count != bbc_pkg::QUEUE_CW'(bbc_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

endmodule

>>> hdl/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back
// Stack engine: executes push and pop commands and forms the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bbc_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          balanced,
  output logic          overflowed
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);

  bbc_pkg::kind_t  stack_mem [STACK_DEPTH];
  bbc_pkg::kind_t  rd_kind;
  bbc_pkg::kind_t  byp_kind;
  logic            byp;
  bbc_pkg::kind_t  top_kind;

  logic [LW-1:0]   level;
  logic [LW-1:0]   level_next;
  logic            mismatch;
  logic            mismatch_next;
  logic            overflow;
  logic            overflow_next;

  logic            take;
  logic            we;
  logic [AW-1:0]   wa;
  logic [AW-1:0]   ra;
  logic            res_balanced;
  logic            res_overflowed;

  assign cmd_ready = !cmd.last || !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;

  // The read port always points at the entry that will be on top next cycle;
  // a push to that same entry is forwarded around the memory.
  assign top_kind = byp ? byp_kind : rd_kind;

  always_comb begin
    level_next     = level;
    mismatch_next  = mismatch;
    overflow_next  = overflow;
    we             = 1'b0;
    wa             = level[AW-1:0];
    res_balanced   = 1'b0;
    res_overflowed = 1'b0;
    if (take) begin
      case (cmd.op)
        bbc_pkg::OP_PUSH: begin
          if (level == LW'(STACK_DEPTH)) begin
            overflow_next = 1'b1;
          end else begin
            we         = 1'b1;
            level_next = level + 1'b1;
          end
        end
        bbc_pkg::OP_POP: begin
          if (level == '0) begin
            mismatch_next = 1'b1;
          end else begin
            level_next = level - 1'b1;
            if (top_kind != cmd.kind) begin
              mismatch_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      res_balanced   = !mismatch_next && !overflow_next && (level_next == '0);
      res_overflowed = overflow_next;
      if (cmd.last) begin
        level_next    = '0;
        mismatch_next = 1'b0;
        overflow_next = 1'b0;
      end
    end
  end

  assign ra = AW'(level_next - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      mismatch <= 1'b0;
      overflow <= 1'b0;
    end else begin
      level    <= level_next;
      mismatch <= mismatch_next;
      overflow <= overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[wa] <= cmd.kind;
    end
    rd_kind  <= stack_mem[ra];
    byp      <= we && (wa == ra);
    byp_kind <= cmd.kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && cmd.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.last) begin
      balanced   <= res_balanced;
      overflowed <= res_overflowed;
    end
  end

endmodule

>>> hdl/bracket_balance_checker.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks that round, square and curly brackets in a byte stream are balanced.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) takes one word per cycle
// while in_ready is high: a byte of expression text in char_code and
// last_char high on its final byte. Bytes other than the six bracket
// characters are ignored. For each word with last_char set, one word
// leaves on the output channel (out_valid/out_ready): balanced is high when
// every bracket matched and none stayed open, overflowed is high when
// nesting went beyond STACK_DEPTH. Throughput is one word per cycle while
// the receiver keeps up; the stack engine then does one push or pop a
// cycle, with a top-of-stack read register and a write-to-read bypass. On
// its way to the result, the final byte passes the classifier register,
// the command queue and the result register.
// When the receiver stalls, the result is held in the output register and
// the stack engine stops at the next final byte. The four-entry command
// queue and the classifier register keep taking bytes until they fill; only
// then does in_ready fall. Reset clears the stack level, the error flags, the
// queue and both valid flags; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_balance_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       balanced,
  output logic       overflowed,
  output logic       out_valid,
  input  logic       out_ready
);

  logic          f_valid;
  logic          f_ready;
  bbc_pkg::cmd_t f_cmd;
  logic          q_valid;
  logic          q_ready;
  bbc_pkg::cmd_t q_cmd;

  bbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .last_char (last_char),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  bbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .balanced   (balanced),
    .overflowed (overflowed)
  );

endmodule
